/* rtl/mrfb_pkg.sv */
// Package for the motion report frame builder: frame constants, default
// sizes and the job record passed from the front end to the byte sequencer.
// No dependencies.
`default_nettype none

package mrfb_pkg;

  // Default sizes handed to the top-level parameters
  localparam int CHANNELS_DEF    = 9;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Frame bytes
  localparam logic [7:0] HDR_SYNC0  = 8'hA5;
  localparam logic [7:0] HDR_SYNC1  = 8'h5A;
  localparam logic [7:0] HDR_LENGTH = 8'(14 + 8);
  localparam logic [7:0] HDR_TYPE   = 8'hA2;
  localparam logic [7:0] SUM_START  = 8'(8'haF + 9);
  localparam logic [7:0] FRAME_TAIL = 8'hAA;

  // Offset applied to negative averages before sending
  localparam logic [15:0] NEG_OFFSET = 16'(32768);

  // One accepted sample, classified and averaged
  typedef struct packed {
    logic        first;  // first channel: header goes out ahead of the data
    logic        last;   // last channel: checksum and tail follow the data
    logic [15:0] code;   // coded average, high byte then low byte
  } job_t;

endpackage

`default_nettype wire

/* rtl/mrfb_queue.sv */
// Small register queue carrying jobs from the front end to the sequencer.
// Depends on mrfb_pkg (job_t).
`default_nettype none

module mrfb_queue
  import mrfb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_data,
  output logic      not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign rd_data   = slot_r[rd_ptr_r];
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/mrfb_front.sv */
// Front end: accepts samples, tracks the channel, updates the per-channel
// running average and writes a coded job. Depends on mrfb_pkg.
`default_nettype none

module mrfb_front
  import mrfb_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [15:0] sample,
  output job_t             job
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  logic [15:0]      avg_r [CHANNELS];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [16:0]      sum_w, adj_w;
  logic [15:0]      avg_w;

  // (old + new) / 2 truncated toward zero: bump odd negatives before shift
  always_comb begin
    sum_w = {avg_r[idx_r][15], avg_r[idx_r]} + {sample[15], sample};
    adj_w = sum_w + {16'b0, sum_w[16] & sum_w[0]};
    avg_w = adj_w[16:1];
  end

  // job record for the sequencer
  always_comb begin
    job.first = (idx_r == '0);
    job.last  = (idx_r == IDX_LAST);
    job.code  = avg_w[15] ? (NEG_OFFSET - avg_w) : avg_w;
  end

  assign idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;

  // channel counter and averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        avg_r[i] <= '0;
      end
    end else if (accept) begin
      idx_r        <= idx_nxt;
      avg_r[idx_r] <= avg_w;
    end
  end

endmodule

`default_nettype wire

/* rtl/mrfb_back.sv */
// Back end: walks each job through its frame bytes, keeps the checksum and
// holds the result register. Depends on mrfb_pkg.
`default_nettype none

module mrfb_back
  import mrfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire logic       head_valid,
  output logic            head_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      tx_byte,
  output logic            frame_end,
  output logic            run_last
);

  // byte position within a job; codes run in send order
  localparam logic [3:0] PH_HDR0 = 4'd0;
  localparam logic [3:0] PH_HDR1 = 4'd1;
  localparam logic [3:0] PH_HDR2 = 4'd2;
  localparam logic [3:0] PH_HDR3 = 4'd3;
  localparam logic [3:0] PH_HI   = 4'd4;
  localparam logic [3:0] PH_LO   = 4'd5;
  localparam logic [3:0] PH_SUM  = 4'd6;
  localparam logic [3:0] PH_END  = 4'd7;
  localparam logic [3:0] PH_NEW  = 4'd8;

  logic [3:0] phase_r, phase_nxt, ph;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] byte_w;
  logic       emit, job_done;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       fe_r, rl_r;

  // a fresh job starts at the header or straight at its data
  assign ph   = (phase_r == PH_NEW) ? (head.first ? PH_HDR0 : PH_HI) : phase_r;
  assign emit = head_valid && (!valid_r || pop);
  assign job_done = (ph == PH_END) || ((ph == PH_LO) && !head.last);
  assign head_pop = emit && job_done;

  // byte select
  always_comb begin
    unique case (ph)
      PH_HDR0: byte_w = HDR_SYNC0;
      PH_HDR1: byte_w = HDR_SYNC1;
      PH_HDR2: byte_w = HDR_LENGTH;
      PH_HDR3: byte_w = HDR_TYPE;
      PH_HI:   byte_w = head.code[15:8];
      PH_LO:   byte_w = head.code[7:0];
      PH_SUM:  byte_w = sum_r;
      PH_END:  byte_w = FRAME_TAIL;
      default: byte_w = FRAME_TAIL;
    endcase
  end

  // sequencing and checksum
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    if (emit) begin
      phase_nxt = job_done ? PH_NEW : ph + 1'b1;
      if (ph == PH_HI || ph == PH_LO) begin
        sum_nxt = sum_r + byte_w;
      end else if (ph == PH_END) begin
        sum_nxt = SUM_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NEW;
      sum_r   <= SUM_START;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      if (emit) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_w;
      fe_r   <= (ph == PH_END);
      rl_r   <= job_done;
    end
  end

  assign empty     = !valid_r;
  assign tx_byte   = byte_r;
  assign frame_end = fe_r;
  assign run_last  = rl_r;

`ifndef SYNTHESIS
  // the frame tail always closes the run of its sample
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && fe_r |-> rl_r)
    else $error("frame tail without run_last");

  // checksum restarts after the tail transfer is produced
  a_sum_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (ph == PH_END) |=> (sum_r == SUM_START) && (phase_r == PH_NEW))
    else $error("checksum not restarted after frame tail");

  // a middle channel job is released after its low byte
  a_mid_release: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (ph == PH_LO) && !head.last |-> head_pop)
    else $error("job not released after low byte");

  // a released job leaves the sequencer ready for a fresh one
  a_new_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> (phase_r == PH_NEW))
    else $error("sequencer not reset after job release");
`endif

endmodule

`default_nettype wire

/* rtl/motion_report_frame_builder.sv */
// Motion report frame builder, top level: front end, job queue and byte
// sequencer. Depends on mrfb_pkg, mrfb_front, mrfb_queue, mrfb_back.
//
// Usage:
//   Input channel: in_sample is taken on a clock edge with push high and
//   full low. Samples arrive in channel order, CHANNELS per frame.
//   Result channel: while empty is low, out_tx_byte, out_frame_end and
//   out_run_last show the oldest byte; it is taken on an edge with pop high.
//   Each sample yields 2 data bytes; the first channel adds 4 header bytes
//   ahead, the last channel adds the checksum and the 0xAA tail.
//   The first byte of a sample becomes visible once it has passed the job
//   queue and then the result register.
//   Throughput: the sequencer sends one byte per cycle while a job is queued
//   and the receiver keeps popping; a 9-channel frame is 24 bytes. The
//   front end takes a sample per cycle while the QUEUE_DEPTH job queue has
//   room; full rises when it fills.
//   Reset (rst_n low, synchronous) clears the channel averages, the channel
//   counter, the checksum, the job queue and the result register.
//   When the receiver holds pop low, the result register holds its byte,
//   the sequencer stops, and the job queue then fills and raises full.
`default_nettype none

module motion_report_frame_builder
  import mrfb_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_sample,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_frame_end,
  output logic             out_run_last
);

  job_t new_job, head_job;
  logic accept, head_valid, head_pop;

  assign accept = push && !full;

  // averaging and classification
  mrfb_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sample (in_sample),
    .job    (new_job)
  );

  // decoupling queue
  mrfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_data   (new_job),
    .full      (full),
    .rd_en     (head_pop),
    .rd_data   (head_job),
    .not_empty (head_valid)
  );

  // byte sequencer and result register
  mrfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_job),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .tx_byte    (out_tx_byte),
    .frame_end  (out_frame_end),
    .run_last   (out_run_last)
  );

endmodule

`default_nettype wire
